// ===== hw/rtl/line_follower_steering_assert.svh =====
// assertion macros shared by the line follower steering checkers
`ifndef LINE_FOLLOWER_STEERING_ASSERT_SVH
`define LINE_FOLLOWER_STEERING_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LFS_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LFS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lfs_pkg.sv =====
// shared types and constants for the line follower steering block
package lfs_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int SENSOR_COUNT_DEF  = 7;

  localparam int DUTY_W = 8;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'd255;
  localparam logic [DUTY_W-1:0] GAIN_RESET = 8'd15;
  localparam logic [DUTY_W-1:0] BASE_RESET = 8'd200;

  localparam logic [MODE_W-1:0] MODE_STRAIGHT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPIN_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPIN_RIGHT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY = 1'd1;

  // control handed from the input stage to the steering stage
  typedef struct packed {
    logic valid;
    logic hit;
    logic led;
  } lfs_s1_t;

endpackage

// ===== hw/rtl/lfs_in_stage.sv =====
// input register and weighted position error of one sensor word
module lfs_in_stage #(
  parameter int SENSOR_COUNT = lfs_pkg::SENSOR_COUNT_DEF,
  parameter int ERR_W        = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SENSOR_COUNT-1:0] in_sensor_bits,
  input  logic                    take,
  output lfs_pkg::lfs_s1_t        s1,
  output logic signed [ERR_W-1:0] s1_err
);

  localparam int Centre = (SENSOR_COUNT - 1) / 2;

  logic                    valid_r;
  logic                    valid_nxt;
  logic [SENSOR_COUNT-1:0] bits_r;
  logic                    load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits_r <= in_sensor_bits;
    end
  end

  // sensor k weighs k minus the centre index
  always_comb begin
    s1_err = '0;
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      if (bits_r[k]) begin
        s1_err = s1_err + ERR_W'(k - Centre);
      end
    end
  end

  assign s1.valid = valid_r;
  assign s1.hit   = |bits_r;
  assign s1.led   = bits_r[Centre];

endmodule

// ===== hw/rtl/lfs_steer.sv =====
// error history, spin decision, duty math and result register
module lfs_steer #(
  parameter int HISTORY_DEPTH = lfs_pkg::HISTORY_DEPTH_DEF,
  parameter int ERR_W         = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfs_pkg::lfs_s1_t            s1,
  input  logic signed [ERR_W-1:0]     s1_err,
  output logic                        take,
  input  logic [lfs_pkg::DUTY_W-1:0]  gain,
  input  logic [lfs_pkg::DUTY_W-1:0]  base_duty,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lfs_pkg::DUTY_W-1:0]  out_right_duty,
  output logic [lfs_pkg::DUTY_W-1:0]  out_left_duty,
  output logic [lfs_pkg::MODE_W-1:0]  out_drive_mode,
  output logic                        out_led_on
);

  localparam int DW     = lfs_pkg::DUTY_W;
  localparam int PROD_W = ERR_W + DW + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

  logic signed [ERR_W-1:0]  hist_r [HISTORY_DEPTH];
  logic                     valid_r;
  logic                     valid_nxt;
  logic [DW-1:0]            right_r;
  logic [DW-1:0]            left_r;
  logic [lfs_pkg::MODE_W-1:0] mode_r;
  logic                     led_r;
  logic                     load;

  logic signed [PROD_W-1:0] change;
  logic signed [SUM_W-1:0]  base_ext;
  logic signed [SUM_W-1:0]  sum_right;
  logic signed [SUM_W-1:0]  sum_left;
  logic [DW-1:0]            right_duty;
  logic [DW-1:0]            left_duty;
  logic [CNT_W-1:0]         neg_cnt;
  logic [CNT_W-1:0]         pos_cnt;
  logic [DW-1:0]            right_val;
  logic [DW-1:0]            left_val;
  logic [lfs_pkg::MODE_W-1:0] mode_val;

  function automatic logic [DW-1:0] clamp_duty(input logic signed [SUM_W-1:0] v);
    logic over;
    over = (v[SUM_W-2:0] > (SUM_W-1)'(lfs_pkg::DUTY_MAX));
    if (v[SUM_W-1]) begin
      clamp_duty = '0;
    end else if (over) begin
      clamp_duty = lfs_pkg::DUTY_MAX;
    end else begin
      clamp_duty = v[DW-1:0];
    end
  endfunction

  assign take = !valid_r || !out_stall;
  assign load = s1.valid && take;

  always_comb begin
    change    = $signed({1'b0, gain}) * s1_err;
    base_ext  = $signed(SUM_W'({1'b0, base_duty}));
    sum_right = base_ext + SUM_W'(change);
    sum_left  = base_ext - SUM_W'(change);
    right_duty = clamp_duty(sum_right);
    left_duty  = clamp_duty(sum_left);
  end

  // sign tally over the stored errors
  always_comb begin
    neg_cnt = '0;
    pos_cnt = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      neg_cnt = neg_cnt + CNT_W'(hist_r[k][ERR_W-1]);
      pos_cnt = pos_cnt + CNT_W'(!hist_r[k][ERR_W-1] && (|hist_r[k]));
    end
  end

  always_comb begin
    if (s1.hit) begin
      right_val = right_duty;
      left_val  = left_duty;
      mode_val  = lfs_pkg::MODE_STRAIGHT;
    end else begin
      right_val = lfs_pkg::DUTY_MAX;
      left_val  = lfs_pkg::DUTY_MAX;
      mode_val  = (neg_cnt > pos_cnt) ? lfs_pkg::MODE_SPIN_LEFT : lfs_pkg::MODE_SPIN_RIGHT;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // oldest entry at index 0, newest error enters at the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else if (load && s1.hit) begin
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        hist_r[k] <= hist_r[k+1];
      end
      hist_r[HISTORY_DEPTH-1] <= s1_err;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      right_r <= right_val;
      left_r  <= left_val;
      mode_r  <= mode_val;
      led_r   <= s1.led;
    end
  end

  assign out_valid      = valid_r;
  assign out_right_duty = right_r;
  assign out_left_duty  = left_r;
  assign out_drive_mode = mode_r;
  assign out_led_on     = led_r;

endmodule

// ===== hw/rtl/line_follower_steering.sv =====
// top level of the line follower proportional steering block
//
//  channel | direction | handshake           | payload
//  in      | sink      | in_valid/in_stall   | in_sensor_bits
//  out     | source    | out_valid/out_stall | out_right_duty, out_left_duty,
//          |           |                     | out_drive_mode, out_led_on
//  cfg     | sink      | cfg_wr_en           | cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; a taken word passes
// the input register and then the result register: the duty math and history
// update run on the input register and load the result register.
// synchronous reset clears the error history, gain to 15 and base duty to 200.
// out_stall holds a full result register and, once the input register is also full,
// raises in_stall in the same cycle.
module line_follower_steering #(
  parameter int HISTORY_DEPTH = lfs_pkg::HISTORY_DEPTH_DEF,
  parameter int SENSOR_COUNT  = lfs_pkg::SENSOR_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SENSOR_COUNT-1:0]           in_sensor_bits,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lfs_pkg::DUTY_W-1:0]        out_right_duty,
  output logic [lfs_pkg::DUTY_W-1:0]        out_left_duty,
  output logic [lfs_pkg::MODE_W-1:0]        out_drive_mode,
  output logic                              out_led_on,
  input  logic                              cfg_wr_en,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // largest error magnitude is the sum of the weights on the longer side
  localparam int Centre = (SENSOR_COUNT - 1) / 2;
  localparam int Side   = SENSOR_COUNT - 1 - Centre;
  localparam int ErrMax = Side * (Side + 1) / 2;
  localparam int ERR_W  = $clog2(ErrMax + 1) + 1;

  logic [lfs_pkg::DUTY_W-1:0] gain_r;
  logic [lfs_pkg::DUTY_W-1:0] base_duty_r;
  lfs_pkg::lfs_s1_t           s1;
  logic signed [ERR_W-1:0]    s1_err;
  logic                       take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= lfs_pkg::GAIN_RESET;
      base_duty_r <= lfs_pkg::BASE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lfs_pkg::REG_GAIN:      gain_r      <= cfg_data[lfs_pkg::DUTY_W-1:0];
        lfs_pkg::REG_BASE_DUTY: base_duty_r <= cfg_data[lfs_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  lfs_in_stage #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .ERR_W        (ERR_W)
  ) u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sensor_bits (in_sensor_bits),
    .take           (take),
    .s1             (s1),
    .s1_err         (s1_err)
  );

  lfs_steer #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ERR_W         (ERR_W)
  ) u_steer (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1             (s1),
    .s1_err         (s1_err),
    .take           (take),
    .gain           (gain_r),
    .base_duty      (base_duty_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_right_duty (out_right_duty),
    .out_left_duty  (out_left_duty),
    .out_drive_mode (out_drive_mode),
    .out_led_on     (out_led_on)
  );

endmodule

// ===== hw/rtl/lfs_checker.sv =====
// port-level checks for the line follower steering block, bound to the top level
`include "line_follower_steering_assert.svh"

module lfs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lfs_pkg::DUTY_W-1:0]     out_right_duty,
  input logic [lfs_pkg::DUTY_W-1:0]     out_left_duty,
  input logic [lfs_pkg::MODE_W-1:0]     out_drive_mode,
  input logic                           out_led_on
);

  logic spin;
  assign spin = out_drive_mode != lfs_pkg::MODE_STRAIGHT;

  // a spin word always runs both motors flat out
  `LFS_CHECK_NOW(a_spin_full_duty, out_valid && spin,
    out_right_duty == lfs_pkg::DUTY_MAX && out_left_duty == lfs_pkg::DUTY_MAX,
    "spin word without full duty")

  // spin comes only from an empty sample, so the centre sensor is dark
  `LFS_CHECK_NOW(a_spin_led_off, out_valid && spin, !out_led_on,
    "spin word with centre sensor lit")

  // a word taken with out_stall low reaches the output while out_stall stays low
  `LFS_CHECK_NEXT(a_latency, (in_valid && !in_stall && !out_stall) ##1 !out_stall,
    out_valid, "accepted word did not reach the output")

  `LFS_CHECK_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_right_duty) && $stable(out_left_duty) &&
    $stable(out_drive_mode) && $stable(out_led_on),
    "stalled output word changed")

endmodule

bind line_follower_steering lfs_checker u_lfs_checker (.*);
